@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define SRBP_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen.
`define SRBP_NEVER(label, expr, msg) `SRBP_CHECK(label, !(expr), msg)

`endif

@@ hdl/srbp_pkg.sv @@
// Types, codes and helper functions of the shape record bit packer.
package srbp_pkg;

	// Record kind
	localparam logic MODE_STATE = 1'b0;
	localparam logic MODE_EDGE  = 1'b1;

	// Change flag bit positions
	localparam int FLAG_MOVE = 0;
	localparam int FLAG_FILL0 = 1;
	localparam int FLAG_FILL1 = 2;
	localparam int FLAG_LINE = 3;
	localparam int FLAG_NEW = 4;

	// Configuration register indexes
	localparam logic CFG_FILL_BITS = 1'b0;
	localparam logic CFG_LINE_BITS = 1'b1;

	localparam int NUM_SEGS = 7;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BOTH     = 2'd1,
		STATUS_WIDTH    = 2'd2,
		STATUS_NEWSTYLE = 2'd3
	} status_t;

	typedef struct packed {
		logic        mode;
		logic [4:0]  flags;
		logic [30:0] x;
		logic [30:0] y;
		logic [16:0] cx;
		logic [16:0] cy;
		logic [16:0] ax;
		logic [16:0] ay;
		logic [14:0] fill0;
		logic [14:0] fill1;
		logic [14:0] line;
	} rec_t;

	typedef struct packed {
		logic [127:0] bits;
		logic [6:0]   total;
		status_t      status;
	} pack_res_t;

	function automatic logic [30:0] abs31(input logic [30:0] v);
		return v[30] ? (31'd0 - v) : v;
	endfunction

	function automatic logic [30:0] sx17(input logic [16:0] v);
		return {{14{v[16]}}, v};
	endfunction

	// Index of the highest set bit; zero for values of one or less.
	function automatic logic [4:0] msb5(input logic [30:0] v);
		logic [4:0] idx;
		idx = '0;
		for (int i = 1; i < 31; i++) begin
			if (v[i]) idx = 5'(i);
		end
		return idx;
	endfunction

	// Place the low n bits of v at bit position p of a 128-bit MSB-first string.
	function automatic logic [127:0] place(input logic [31:0] v, input logic [5:0] n,
			input logic [6:0] p);
		logic [31:0]  m;
		logic [127:0] a;
		m = v & ~(32'hFFFF_FFFF << n);
		a = {m, 96'b0} << (6'd32 - n);
		return a >> p;
	endfunction

endpackage

@@ hdl/shape_record_bit_packer_core.sv @@
// Shape record bit packer: input register, packing logic, chunk output register.
//
//   Channel | Handshake              | Words
//   in      | in_valid / in_stall    | one shape record per word
//   out     | out_valid / out_stall  | one 64-bit chunk per word, one or two per record
//   cfg     | cfg_wr_en              | style index widths, index 0 fill, 1 line
//
// A record of up to 64 bits leaves as one word, a longer one as two words in turn;
// the block takes one record per cycle while out_stall is low and records fit one chunk.
// An accepted record moves from the input register to the result register, which shows its first chunk.
// Reset clears the valid flags, the chunk phase and both width registers.
// out_stall holds the current chunk; in_stall rises only when the input register
// is full and the output register cannot take its record.
module shape_record_bit_packer_core import srbp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [4:0]         change_flags,
	input  logic signed [30:0] move_or_line_x,
	input  logic signed [30:0] move_or_line_y,
	input  logic signed [16:0] control_dx,
	input  logic signed [16:0] control_dy,
	input  logic signed [16:0] anchor_dx,
	input  logic signed [16:0] anchor_dy,
	input  logic [14:0]        fill0_index,
	input  logic [14:0]        fill1_index,
	input  logic [14:0]        line_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [63:0]        bit_chunk,
	output logic [6:0]         chunk_bit_count,
	output logic               last_chunk,
	output logic [1:0]         status
);

	logic [3:0] fill_width_q;
	logic [3:0] line_width_q;
	rec_t       rec_s1;
	logic       valid_s1;
	pack_res_t  pack_res;
	pack_res_t  res_s2;
	logic       valid_s2;
	logic       phase_q;
	logic       two_chunks;
	logic       out_take;
	logic       out_done;
	logic       load_s2;
	logic       in_take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_width_q <= '0;
			line_width_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FILL_BITS: fill_width_q <= cfg_data;
				CFG_LINE_BITS: line_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake control
	assign two_chunks = res_s2.total > 7'd64;
	assign last_chunk = phase_q || !two_chunks;
	assign out_take = valid_s2 && !out_stall;
	assign out_done = out_take && last_chunk;
	assign load_s2 = valid_s1 && (!valid_s2 || out_done);
	assign in_stall = valid_s1 && !load_s2;
	assign in_take = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rec_s1.mode <= mode;
			rec_s1.flags <= change_flags;
			rec_s1.x <= move_or_line_x;
			rec_s1.y <= move_or_line_y;
			rec_s1.cx <= control_dx;
			rec_s1.cy <= control_dy;
			rec_s1.ax <= anchor_dx;
			rec_s1.ay <= anchor_dy;
			rec_s1.fill0 <= fill0_index;
			rec_s1.fill1 <= fill1_index;
			rec_s1.line <= line_index;
		end
	end

	srbp_pack u_pack (
		.rec        (rec_s1),
		.fill_width (fill_width_q),
		.line_width (line_width_q),
		.res        (pack_res)
	);

	// Result register and chunk phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			phase_q <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
			phase_q <= 1'b0;
		end else if (out_done) begin
			valid_s2 <= 1'b0;
			phase_q <= 1'b0;
		end else if (out_take) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			res_s2 <= pack_res;
		end
	end

	// Select the chunk for the current phase
	assign out_valid = valid_s2;
	assign bit_chunk = phase_q ? res_s2.bits[63:0] : res_s2.bits[127:64];
	assign chunk_bit_count = phase_q ? (res_s2.total - 7'd64) :
		(two_chunks ? 7'd64 : res_s2.total);
	assign status = res_s2.status;

endmodule

@@ hdl/srbp_pack.sv @@
// Width detect, error checks and bit placement for one shape record.
module srbp_pack import srbp_pkg::*; (
	input  rec_t       rec,
	input  logic [3:0] fill_width,
	input  logic [3:0] line_width,
	output pack_res_t  res
);

	logic [30:0] xy_or;
	logic [30:0] crv_or;
	logic        is_line;
	logic        curve_nz;
	logic [4:0]  k_xy;
	logic [4:0]  k_crv;
	logic [4:0]  k_sel;
	logic [5:0]  w;
	logic [31:0] seg_val [NUM_SEGS];
	logic [5:0]  seg_len [NUM_SEGS];
	logic [6:0]  seg_pos [NUM_SEGS];
	logic [127:0] bits;
	logic [6:0]  total;
	status_t     st;
	logic        err;

	// Width scan: highest set bit of the ORed magnitudes
	assign xy_or = abs31(rec.x) | abs31(rec.y);
	assign crv_or = abs31(sx17(rec.cx)) | abs31(sx17(rec.cy)) |
		abs31(sx17(rec.ax)) | abs31(sx17(rec.ay));
	assign is_line = (rec.x != '0) || (rec.y != '0);
	assign curve_nz = (rec.cx != '0) || (rec.cy != '0) || (rec.ax != '0) || (rec.ay != '0);
	assign k_xy = msb5(xy_or);
	assign k_crv = msb5(crv_or);
	assign k_sel = (rec.mode == MODE_EDGE && !is_line) ? k_crv : k_xy;
	assign w = {1'b0, k_sel} + 6'd2;

	// Select segments and status per record kind
	always_comb begin
		for (int i = 0; i < NUM_SEGS; i++) begin
			seg_val[i] = '0;
			seg_len[i] = '0;
		end
		st = STATUS_OK;
		case (rec.mode)
			MODE_STATE: begin
				seg_val[0] = {26'b0, 1'b0, rec.flags};
				seg_len[0] = 6'd6;
				if (rec.flags[FLAG_MOVE]) begin
					seg_val[1] = {26'b0, w};
					seg_len[1] = 6'd5;
					seg_val[2] = {1'b0, rec.x};
					seg_len[2] = w;
					seg_val[3] = {1'b0, rec.y};
					seg_len[3] = w;
				end
				if (rec.flags[FLAG_FILL0]) begin
					seg_val[4] = {17'b0, rec.fill0};
					seg_len[4] = {2'b0, fill_width};
				end
				if (rec.flags[FLAG_FILL1]) begin
					seg_val[5] = {17'b0, rec.fill1};
					seg_len[5] = {2'b0, fill_width};
				end
				if (rec.flags[FLAG_LINE]) begin
					seg_val[6] = {17'b0, rec.line};
					seg_len[6] = {2'b0, line_width};
				end
				if (rec.flags[FLAG_MOVE] && k_xy >= 5'd30) st = STATUS_WIDTH;
				else if (rec.flags[FLAG_NEW]) st = STATUS_NEWSTYLE;
			end
			MODE_EDGE: begin
				if (is_line) begin
					seg_val[0] = {26'b0, 2'b11, k_sel[3:0]};
					seg_len[0] = 6'd6;
					if (rec.x == '0) begin
						seg_val[1] = 32'd1;
						seg_len[1] = 6'd2;
						seg_val[2] = {1'b0, rec.y};
						seg_len[2] = w;
					end else if (rec.y == '0) begin
						seg_val[1] = 32'd0;
						seg_len[1] = 6'd2;
						seg_val[2] = {1'b0, rec.x};
						seg_len[2] = w;
					end else begin
						seg_val[1] = 32'd1;
						seg_len[1] = 6'd1;
						seg_val[2] = {1'b0, rec.x};
						seg_len[2] = w;
						seg_val[3] = {1'b0, rec.y};
						seg_len[3] = w;
					end
					if (curve_nz) st = STATUS_BOTH;
					else if (k_sel[4]) st = STATUS_WIDTH;
				end else begin
					seg_val[0] = {26'b0, 2'b10, k_sel[3:0]};
					seg_len[0] = 6'd6;
					seg_val[1] = {15'b0, rec.cx};
					seg_len[1] = w;
					seg_val[2] = {15'b0, rec.cy};
					seg_len[2] = w;
					seg_val[3] = {15'b0, rec.ax};
					seg_len[3] = w;
					seg_val[4] = {15'b0, rec.ay};
					seg_len[4] = w;
					if (k_sel[4]) st = STATUS_WIDTH;
				end
			end
			default: st = STATUS_OK;
		endcase
	end

	// Start positions by running sum of segment lengths, then OR the segments in
	always_comb begin
		seg_pos[0] = '0;
		for (int i = 1; i < NUM_SEGS; i++) begin
			seg_pos[i] = seg_pos[i-1] + {1'b0, seg_len[i-1]};
		end
		total = seg_pos[NUM_SEGS-1] + {1'b0, seg_len[NUM_SEGS-1]};
		bits = '0;
		for (int i = 0; i < NUM_SEGS; i++) begin
			bits = bits | place(seg_val[i], seg_len[i], seg_pos[i]);
		end
	end

	// Drop the record on an error: one empty chunk carries the status
	assign err = (st == STATUS_BOTH) || (st == STATUS_WIDTH);
	assign res.bits = err ? '0 : bits;
	assign res.total = err ? '0 : total;
	assign res.status = st;

endmodule

@@ hdl/srbp_checker.sv @@
// Port-level checker for the shape record bit packer, with its bind.
`include "assert_macros.svh"

module srbp_checker import srbp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] bit_chunk,
	input logic [6:0]  chunk_bit_count,
	input logic        last_chunk,
	input logic [1:0]  status
);

	// A chunk before the last is always full
	`SRBP_CHECK(a_full_first, out_valid && !last_chunk |-> chunk_bit_count == 7'd64, "short non-final chunk")

	// Bits past the count are zero
	`SRBP_CHECK(a_pad_zero, out_valid && chunk_bit_count < 7'd64 |-> (bit_chunk & (64'hFFFF_FFFF_FFFF_FFFF >> chunk_bit_count)) == '0, "nonzero padding bits")

	// An error record is one empty final chunk
	`SRBP_CHECK(a_err_empty, out_valid && (status == STATUS_BOTH || status == STATUS_WIDTH) |-> chunk_bit_count == '0 && last_chunk && bit_chunk == '0, "error chunk not empty")

	// The second chunk of a record follows at once
	`SRBP_CHECK(a_second_follows, out_valid && !out_stall && !last_chunk |=> out_valid && last_chunk, "second chunk missing")

	// A stalled chunk holds
	`SRBP_NEVER(a_stall_hold, $past(out_valid && out_stall) && !$stable(bit_chunk), "stalled chunk changed")

endmodule

bind shape_record_bit_packer_core srbp_checker u_srbp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.bit_chunk       (bit_chunk),
	.chunk_bit_count (chunk_bit_count),
	.last_chunk      (last_chunk),
	.status          (status)
);
